[rtl/core/ltce_pkg.sv]
// ----------------------------------------------------------------------------
// ltce_pkg: shared definitions for the leg trajectory cubic evaluator
// Register map, fixed field widths, scale constants and coefficient types.
// ----------------------------------------------------------------------------
package ltce_pkg;

    // Default widths for the phase word and the fraction of all fixed-point values.
    localparam int PHASE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Configuration register file.
    localparam int NUM_REGS    = 8;
    localparam int REG_W       = 24;
    localparam int CFG_INDEX_W = $clog2(NUM_REGS);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CH0_W2,
        REG_CH0_W3,
        REG_CH1_W2,
        REG_CH1_W3,
        REG_CH2_W2,
        REG_CH2_W3,
        REG_CH3_W2,
        REG_CH3_W3
    } cfg_reg_e;

    typedef logic signed [REG_W-1:0] cfg_word_t;

    localparam cfg_word_t CFG_RESET [NUM_REGS] = '{
        24'sd34865, -24'sd135582, -24'sd406062, -24'sd61778,
        -24'sd96990, -24'sd74791, 24'sd319407, 24'sd50253
    };

    // Four channels, each a weighted sum of four cubic terms.
    localparam int NUM_CH    = 4;
    localparam int NUM_TERMS = 4;

    // A derived weight 6*w3 - w2 needs three more bits than a register.
    localparam int WEIGHT_W = REG_W + 3;

    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef weight_t [NUM_TERMS-1:0]    chan_coef_t;
    typedef chan_coef_t [NUM_CH-1:0]    coef_set_t;

    // Output scale factors as unsigned Q0.32, rounded to nearest, held in a
    // signed operand one bit wider than their magnitude.
    localparam int SCALE_W     = 27;
    localparam int SCALE_SHIFT = 32;
    localparam logic signed [SCALE_W-1:0] SCALE_EVEN = 27'sd48318382;  // 0.045 / 4
    localparam logic signed [SCALE_W-1:0] SCALE_ODD  = 27'sd64424509;  // 0.045 / 3

    // Result fields.
    localparam int OUT_W   = 22;
    localparam int OUT_MAX = (2 ** (OUT_W - 1)) - 1;
    localparam int OUT_MIN = -(2 ** (OUT_W - 1));

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

endpackage

[rtl/core/ltce_cfg.sv]
// ----------------------------------------------------------------------------
// ltce_cfg: coefficient register file
// Holds the eight weight registers and builds the sixteen channel weights.
// ----------------------------------------------------------------------------
module ltce_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ltce_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ltce_pkg::REG_W-1:0]          cfg_data,
    output ltce_pkg::coef_set_t                 coef
);

    ltce_pkg::cfg_word_t regs_reg [ltce_pkg::NUM_REGS];
    ltce_pkg::weight_t   d_reg    [ltce_pkg::NUM_CH];
    ltce_pkg::weight_t   d_next   [ltce_pkg::NUM_CH];
    ltce_pkg::cfg_word_t w2_ch    [ltce_pkg::NUM_CH];
    ltce_pkg::cfg_word_t w3_ch    [ltce_pkg::NUM_CH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ltce_pkg::NUM_REGS; i++)
            begin
                regs_reg[i] <= ltce_pkg::CFG_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        w2_ch[0] = regs_reg[ltce_pkg::REG_CH0_W2];
        w3_ch[0] = regs_reg[ltce_pkg::REG_CH0_W3];
        w2_ch[1] = regs_reg[ltce_pkg::REG_CH1_W2];
        w3_ch[1] = regs_reg[ltce_pkg::REG_CH1_W3];
        w2_ch[2] = regs_reg[ltce_pkg::REG_CH2_W2];
        w3_ch[2] = regs_reg[ltce_pkg::REG_CH2_W3];
        w2_ch[3] = regs_reg[ltce_pkg::REG_CH3_W2];
        w3_ch[3] = regs_reg[ltce_pkg::REG_CH3_W3];
    end

    // The derived weight 6*w3 - w2 is registered so that no adder sits in
    // front of the weight multipliers. It follows a write in the next cycle.
    always_comb
    begin
        for (int c = 0; c < ltce_pkg::NUM_CH; c++)
        begin
            d_next[c] = (ltce_pkg::WEIGHT_W'(w3_ch[c]) <<< 2)
                      + (ltce_pkg::WEIGHT_W'(w3_ch[c]) <<< 1)
                      - ltce_pkg::WEIGHT_W'(w2_ch[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < ltce_pkg::NUM_CH; c++)
        begin
            d_reg[c] <= d_next[c];
        end
    end

    // Channel c borrows its first two weights from its partner channel c^2.
    always_comb
    begin
        for (int c = 0; c < ltce_pkg::NUM_CH; c++)
        begin
            coef[c][0] = ltce_pkg::WEIGHT_W'(w3_ch[2'(c ^ 2)]);
            coef[c][1] = d_reg[2'(c ^ 2)];
            coef[c][2] = ltce_pkg::WEIGHT_W'(w2_ch[c]);
            coef[c][3] = ltce_pkg::WEIGHT_W'(w3_ch[c]);
        end
    end

endmodule

[rtl/core/ltce_front.sv]
// ----------------------------------------------------------------------------
// ltce_front: phase intake
// Accepts phase beats, splits off the half flag and forms tau and 1 - tau.
// ----------------------------------------------------------------------------
module ltce_front #(
    parameter int PHASE_BITS = ltce_pkg::PHASE_BITS_DEF,
    parameter int FRAC_BITS  = ltce_pkg::FRAC_BITS_DEF
) (
    input  logic                     push,
    output logic                     full,
    input  logic [PHASE_BITS-1:0]    phase,
    input  logic                     q_full,
    output logic                     q_wr,
    output logic [2*FRAC_BITS+1:0]   q_wdata
);

    localparam int EXT_W = PHASE_BITS - 1 + FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic                 half;
    logic [EXT_W-1:0]     ext;
    logic [FRAC_BITS-1:0] tq;
    logic [FRAC_BITS:0]   uq;

    assign full = q_full;
    assign q_wr = push && !q_full;

    // tau is the phase fraction below the half bit, brought to FRAC_BITS bits
    // by a left shift followed by dropping the low PHASE_BITS-1 bits.
    assign half = phase[PHASE_BITS-1];
    assign ext  = {phase[PHASE_BITS-2:0], {FRAC_BITS{1'b0}}};
    assign tq   = ext[EXT_W-1 -: FRAC_BITS];
    assign uq   = ONE - {1'b0, tq};

    assign q_wdata = {half, tq, uq};

endmodule

[rtl/core/ltce_fifo.sv]
// ----------------------------------------------------------------------------
// ltce_fifo: short queue between the front and the back
// Register-based first-in first-out buffer with a fill count.
// ----------------------------------------------------------------------------
module ltce_fifo #(
    parameter int WIDTH = 34,
    parameter int DEPTH = ltce_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [WIDTH-1:0]  wr_data,
    output logic              full,
    input  logic              rd_en,
    output logic [WIDTH-1:0]  rd_data,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_ok;
    logic             pop_ok;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = wr_en && !full;
    assign pop_ok  = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push_ok && pop_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_up : assert property (@(posedge clk) disable iff (!rst_n)
        (push_ok && !pop_ok) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not rise on a lone write");

    a_count_down : assert property (@(posedge clk) disable iff (!rst_n)
        (!push_ok && pop_ok) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not fall on a lone read");

endmodule

[rtl/core/ltce_back.sv]
// ----------------------------------------------------------------------------
// ltce_back: evaluation pipeline
// Five arithmetic stages and a result register, stalled as one when the
// result waits.
// ----------------------------------------------------------------------------
module ltce_back #(
    parameter int FRAC_BITS = ltce_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  logic [2*FRAC_BITS+1:0]              q_rdata,
    output logic                                q_rd,
    input  ltce_pkg::coef_set_t                 coef,
    input  logic                                pop,
    output logic                                empty,
    output logic signed [ltce_pkg::OUT_W-1:0]   leg1_x,
    output logic signed [ltce_pkg::OUT_W-1:0]   leg1_y,
    output logic signed [ltce_pkg::OUT_W-1:0]   leg2_x,
    output logic signed [ltce_pkg::OUT_W-1:0]   leg2_y,
    output logic                                stance_half
);

    localparam int F      = FRAC_BITS;
    localparam int U_W    = F + 1;                              // tau, 1-tau, basis
    localparam int SQ_W   = 2 * U_W;                            // raw unsigned products
    localparam int PW     = ltce_pkg::WEIGHT_W + U_W + 1;       // weight * basis
    localparam int ACC_W  = PW + 2;
    localparam int Y_W    = ACC_W - F;
    localparam int SP_W   = Y_W + ltce_pkg::SCALE_W;
    localparam int R_W    = SP_W - ltce_pkg::SCALE_SHIFT;
    localparam int V_W    = R_W + 2;
    localparam int NC     = ltce_pkg::NUM_CH;
    localparam int NT     = ltce_pkg::NUM_TERMS;
    localparam int OW     = ltce_pkg::OUT_W;

    localparam longint OFFSET_L = ((longint'(1) << F) * 2 + 5) / 10;

    localparam logic [SQ_W-1:0]         RND_U   = SQ_W'(longint'(1) << (F - 1));
    localparam logic signed [ACC_W-1:0] RND_ACC = ACC_W'(longint'(1) << (F - 1));
    localparam logic signed [SP_W-1:0]  RND_SP  =
        SP_W'(longint'(1) << (ltce_pkg::SCALE_SHIFT - 1));
    localparam logic signed [V_W-1:0]   OFFSET  = V_W'(OFFSET_L);
    localparam logic signed [V_W-1:0]   SAT_HI  = V_W'(ltce_pkg::OUT_MAX);
    localparam logic signed [V_W-1:0]   SAT_LO  = V_W'(ltce_pkg::OUT_MIN);

    logic             advance;
    logic             q_half;
    logic [F-1:0]     q_tq;
    logic [F:0]       q_uq;

    // Stage 1: squares of tau and 1 - tau.
    logic             s1_valid_reg;
    logic             s1_half_reg;
    logic [U_W-1:0]   s1_tq_reg;
    logic [U_W-1:0]   s1_uq_reg;
    logic [SQ_W-1:0]  s1_tt_reg;
    logic [SQ_W-1:0]  s1_uu_reg;

    // Stage 2: raw cubic terms.
    logic             s2_valid_reg;
    logic             s2_half_reg;
    logic [U_W-1:0]   tt;
    logic [U_W-1:0]   uu;
    logic [SQ_W-1:0]  s2_b_next [NT];
    logic [SQ_W-1:0]  s2_b_reg  [NT];

    // Stage 3: weighted terms, one product per channel and term.
    logic                    s3_valid_reg;
    logic                    s3_half_reg;
    logic [U_W-1:0]          basis [NT];
    logic signed [PW-1:0]    s3_p_next [NC][NT];
    logic signed [PW-1:0]    s3_p_reg  [NC][NT];

    // Stage 4: channel sums rounded to the fraction width.
    logic                    s4_valid_reg;
    logic                    s4_half_reg;
    logic signed [ACC_W-1:0] acc   [NC];
    logic signed [ACC_W-1:0] acc_r [NC];
    logic signed [Y_W-1:0]   s4_y_reg [NC];

    // Stage 5: scaled channels.
    logic                    s5_valid_reg;
    logic                    s5_half_reg;
    logic signed [SP_W-1:0]  s5_sp_next [NC];
    logic signed [SP_W-1:0]  s5_sp_reg  [NC];

    // Result register.
    logic                    out_valid_reg;
    logic                    out_half_reg;
    logic signed [SP_W-1:0]  sp_r  [NC];
    logic signed [R_W-1:0]   r     [NC];
    logic signed [V_W-1:0]   v     [NC];
    logic signed [OW-1:0]    out_next [NC];
    logic signed [OW-1:0]    out_reg  [NC];

    // The whole pipe moves when the result register is free or being taken.
    assign advance = !out_valid_reg || pop;
    assign q_rd    = advance && !q_empty;
    assign {q_half, q_tq, q_uq} = q_rdata;

    always_comb
    begin
        tt = U_W'((s1_tt_reg + RND_U) >> F);
        uu = U_W'((s1_uu_reg + RND_U) >> F);
        s2_b_next[0] = SQ_W'(uu) * SQ_W'(s1_uq_reg);
        s2_b_next[1] = SQ_W'(uu) * SQ_W'(s1_tq_reg);
        s2_b_next[2] = SQ_W'(tt) * SQ_W'(s1_uq_reg);
        s2_b_next[3] = SQ_W'(tt) * SQ_W'(s1_tq_reg);
    end

    always_comb
    begin
        for (int j = 0; j < NT; j++)
        begin
            basis[j] = U_W'((s2_b_reg[j] + RND_U) >> F);
        end
        for (int c = 0; c < NC; c++)
        begin
            for (int j = 0; j < NT; j++)
            begin
                s3_p_next[c][j] = PW'($signed(coef[c][j]))
                                * PW'($signed({1'b0, basis[j]}));
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            acc[c]   = ACC_W'(s3_p_reg[c][0]) + ACC_W'(s3_p_reg[c][1])
                     + ACC_W'(s3_p_reg[c][2]) + ACC_W'(s3_p_reg[c][3]);
            acc_r[c] = (acc[c] + RND_ACC) >>> F;
        end
    end

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            if ((c & 1) == 0)
            begin
                s5_sp_next[c] = SP_W'(s4_y_reg[c]) * SP_W'(ltce_pkg::SCALE_EVEN);
            end
            else
            begin
                s5_sp_next[c] = SP_W'(s4_y_reg[c]) * SP_W'(ltce_pkg::SCALE_ODD);
            end
        end
    end

    // Round back from Q0.32 scaling, add the offset and negate the even
    // channels, then clamp to the result width.
    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            sp_r[c] = (s5_sp_reg[c] + RND_SP) >>> ltce_pkg::SCALE_SHIFT;
            r[c]    = sp_r[c][R_W-1:0];
            if ((c & 1) == 0)
            begin
                v[c] = -(V_W'(r[c]) + OFFSET);
            end
            else
            begin
                v[c] = V_W'(r[c]);
            end
            if (v[c] > SAT_HI)
            begin
                out_next[c] = SAT_HI[OW-1:0];
            end
            else if (v[c] < SAT_LO)
            begin
                out_next[c] = SAT_LO[OW-1:0];
            end
            else
            begin
                out_next[c] = v[c][OW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= q_rd;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_half_reg  <= q_half;
            s1_tq_reg    <= {1'b0, q_tq};
            s1_uq_reg    <= q_uq;
            s1_tt_reg    <= SQ_W'(q_tq) * SQ_W'(q_tq);
            s1_uu_reg    <= SQ_W'(q_uq) * SQ_W'(q_uq);
            s2_half_reg  <= s1_half_reg;
            s3_half_reg  <= s2_half_reg;
            s4_half_reg  <= s3_half_reg;
            s5_half_reg  <= s4_half_reg;
            out_half_reg <= s5_half_reg;
            for (int j = 0; j < NT; j++)
            begin
                s2_b_reg[j] <= s2_b_next[j];
            end
            for (int c = 0; c < NC; c++)
            begin
                for (int j = 0; j < NT; j++)
                begin
                    s3_p_reg[c][j] <= s3_p_next[c][j];
                end
                s4_y_reg[c]  <= acc_r[c][Y_W-1:0];
                s5_sp_reg[c] <= s5_sp_next[c];
                out_reg[c]   <= out_next[c];
            end
        end
    end

    assign empty       = !out_valid_reg;
    assign leg1_x      = out_reg[1];
    assign leg1_y      = out_reg[0];
    assign leg2_x      = out_reg[3];
    assign leg2_y      = out_reg[2];
    assign stance_half = out_half_reg;

    a_bubble_reaches_out : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !s5_valid_reg) |=> !out_valid_reg)
        else $error("result shown without an item behind it");

    a_frozen_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> ($stable(s5_valid_reg) && $stable(s1_valid_reg)))
        else $error("pipeline moved while the result was waiting");

    a_no_read_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |-> !q_rd)
        else $error("queue read while the pipeline was stalled");

endmodule

[rtl/core/leg_trajectory_cubic_eval_unit.sv]
// ----------------------------------------------------------------------------
// leg_trajectory_cubic_eval_unit: foot trajectory from a gait phase
// A phase word goes in; two leg x/y positions and the half flag come out.
// ----------------------------------------------------------------------------
// Use of the block:
//   Input side is a queue: drive phase and raise push while full is low;
//   each such edge takes one beat. Output side is a queue too: while empty is
//   low the oldest result sits on leg1_x, leg1_y, leg2_x, leg2_y and
//   stance_half, and an edge with pop high takes it.
//   Every phase beat gives exactly one result beat, in order.
//   A beat passes from the accepting edge through the four-entry front queue,
//   the evaluation pipe stages and the result register. The pipe takes one
//   beat every cycle while the result register is free or being popped,
//   so a steady stream runs at one result per cycle; its sixteen weight
//   multipliers and four scale multipliers are each used once per beat. If
//   the receiver stops popping, the pipe holds in place, the four-entry queue
//   fills and full rises; nothing is dropped. The eight weight registers are
//   written through cfg_we, cfg_index and cfg_data; the user must write them
//   only while the block is idle, which the block does not enforce. Derived
//   weights follow a write through a register. Reset clears the queue and the
//   pipe (full and empty show an idle block) and loads the default weights.
// ----------------------------------------------------------------------------
module leg_trajectory_cubic_eval_unit #(
    parameter int PHASE_BITS = ltce_pkg::PHASE_BITS_DEF,
    parameter int FRAC_BITS  = ltce_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [PHASE_BITS-1:0]               phase,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [ltce_pkg::OUT_W-1:0]   leg1_x,
    output logic signed [ltce_pkg::OUT_W-1:0]   leg1_y,
    output logic signed [ltce_pkg::OUT_W-1:0]   leg2_x,
    output logic signed [ltce_pkg::OUT_W-1:0]   leg2_y,
    output logic                                stance_half,
    input  logic                                cfg_we,
    input  logic [ltce_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ltce_pkg::REG_W-1:0]          cfg_data
);

    // A queue entry carries the half flag, tau and 1 - tau.
    localparam int ENTRY_W = 2 * FRAC_BITS + 2;

    logic                 q_full;
    logic                 q_wr;
    logic [ENTRY_W-1:0]   q_wdata;
    logic                 q_empty;
    logic                 q_rd;
    logic [ENTRY_W-1:0]   q_rdata;
    ltce_pkg::coef_set_t  coef;

    ltce_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    // The front only splits the phase word, so it writes the queue directly.
    ltce_front #(
        .PHASE_BITS (PHASE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .push    (push),
        .full    (full),
        .phase   (phase),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_wdata (q_wdata)
    );

    ltce_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (ltce_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    // The back pulls from the queue whenever its pipe can move and owns the
    // result register that the output side reads.
    ltce_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_rdata     (q_rdata),
        .q_rd        (q_rd),
        .coef        (coef),
        .pop         (pop),
        .empty       (empty),
        .leg1_x      (leg1_x),
        .leg1_y      (leg1_y),
        .leg2_x      (leg2_x),
        .leg2_y      (leg2_y),
        .stance_half (stance_half)
    );

endmodule
